// ===== rtl/sxg_pkg.sv =====
// ----------------------------------------------------------------------------
// sxg_pkg
// shared constants and types of the signed extended gcd unit
// ----------------------------------------------------------------------------
package sxg_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/sxg_if.sv =====
// ----------------------------------------------------------------------------
// sxg interfaces
// operand and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface sxg_in_if import sxg_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface sxg_out_if import sxg_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic        [DATA_WIDTH-2:0] divisor;
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;

    modport source (output valid, output divisor, output coef_a, output coef_b, input ready);
    modport sink   (input valid, input divisor, input coef_a, input coef_b, output ready);
endinterface

// ===== rtl/signed_extended_gcd_unit.sv =====
// ----------------------------------------------------------------------------
// signed_extended_gcd_unit
// gcd and bezout coefficients of two signed operands on one shared divider
// ----------------------------------------------------------------------------
//  channel | dir | fields                      | handshake
//  i_in    | in  | operand_a, operand_b        | valid / ready
//  o_out   | out | divisor, coef_a, coef_b     | valid / ready
//
//  an operand of zero skips the divider: the sequencer goes from idle straight
//  to the final state; otherwise it runs k euclid steps, k = number of steps
//  (up to about 46 for 32 bits); each step is a pass of the one-bit restoring
//  divider over all DATA_WIDTH dividend bits plus a coefficient update state
//  i_in.ready is high only while idle, so no new beat is taken until the last
//  is done; a finished result waits in the output register while the next
//  beat is taken, and a full output register holds the sequencer at the end
//  reset is synchronous, active low, and clears the sequencer and o_out.valid
// ----------------------------------------------------------------------------
module signed_extended_gcd_unit import sxg_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    sxg_in_if.sink    i_in,
    sxg_out_if.source o_out
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);

    t_state r_state;
    t_state n_state;

    logic [W-1:0]  r_dvd;
    logic [W-1:0]  r_small;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_p0;
    logic [W-1:0]  r_p1;
    logic [W-1:0]  r_q0;
    logic [W-1:0]  r_q1;
    logic [W-1:0]  r_tp;
    logic [W-1:0]  r_tq;
    logic [CW-1:0] r_cnt;
    logic          r_swap;
    logic          r_neg_a;
    logic          r_neg_b;

    logic          r_out_valid;
    logic [W-2:0]  r_divisor;
    logic [W-1:0]  r_coef_a;
    logic [W-1:0]  r_coef_b;

    logic          w_accept;
    logic          w_out_free;
    logic          w_div_last;
    logic          w_in_ready;
    logic          w_out_load;

    logic          w_neg_a;
    logic          w_neg_b;
    logic [W-1:0]  w_mag_a;
    logic [W-1:0]  w_mag_b;
    logic          w_zero;
    logic          w_swap;

    logic [W:0]    w_shift;
    logic [W:0]    w_diff;
    logic          w_qbit;
    logic [W-1:0]  w_rem_nx;
    logic [W-1:0]  w_tp_nx;
    logic [W-1:0]  w_tq_nx;

    logic [W-1:0]  w_ka_mag;
    logic [W-1:0]  w_lb_mag;

    // operand conditioning
    assign w_neg_a = i_in.operand_a[W-1];
    assign w_neg_b = i_in.operand_b[W-1];
    assign w_mag_a = w_neg_a ? (W'(0) - W'(i_in.operand_a)) : W'(i_in.operand_a);
    assign w_mag_b = w_neg_b ? (W'(0) - W'(i_in.operand_b)) : W'(i_in.operand_b);
    assign w_zero  = (w_mag_a == '0) || (w_mag_b == '0);
    assign w_swap  = (w_mag_a < w_mag_b) || ((w_mag_a == w_mag_b) && !w_neg_a && w_neg_b);

    // one restoring divide step with quotient-times-coefficient lanes
    assign w_shift  = {r_rem, r_dvd[W-1]};
    assign w_diff   = w_shift - {1'b0, r_small};
    assign w_qbit   = !w_diff[W];
    assign w_rem_nx = w_qbit ? w_diff[W-1:0] : w_shift[W-1:0];
    assign w_tp_nx  = {r_tp[W-2:0], 1'b0} + (w_qbit ? r_p1 : '0);
    assign w_tq_nx  = {r_tq[W-2:0], 1'b0} + (w_qbit ? r_q1 : '0);

    assign w_ka_mag = r_swap ? r_q1 : r_p1;
    assign w_lb_mag = r_swap ? r_p1 : r_q1;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_div_last = (r_cnt == CW'(W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = w_zero ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_last) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_state = (r_rem == '0) ? ST_FIN : ST_DIV;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_DIV:  ;
            ST_UPD:  ;
            ST_FIN:  w_out_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // euclid datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg_a <= w_neg_a;
            r_neg_b <= w_neg_b;
            r_rem   <= '0;
            r_tp    <= '0;
            r_tq    <= '0;
            r_cnt   <= '0;
            r_p0    <= W'(1);
            r_q0    <= '0;
            if (w_mag_a == '0) begin
                r_swap  <= 1'b0;
                r_small <= w_mag_b;
                r_p1    <= '0;
                r_q1    <= W'(1);
            end else if (w_mag_b == '0) begin
                r_swap  <= 1'b0;
                r_small <= w_mag_a;
                r_p1    <= W'(1);
                r_q1    <= '0;
            end else begin
                r_swap  <= w_swap;
                r_dvd   <= w_swap ? w_mag_b : w_mag_a;
                r_small <= w_swap ? w_mag_a : w_mag_b;
                r_p1    <= '0;
                r_q1    <= W'(1);
            end
        end else if (r_state == ST_DIV) begin
            r_rem <= w_rem_nx;
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            r_tp  <= w_tp_nx;
            r_tq  <= w_tq_nx;
            r_cnt <= r_cnt + CW'(1);
        end else if (r_state == ST_UPD && r_rem != '0) begin
            r_p0    <= r_p1;
            r_p1    <= r_p0 - r_tp;
            r_q0    <= r_q1;
            r_q1    <= r_q0 - r_tq;
            r_dvd   <= r_small;
            r_small <= r_rem;
            r_rem   <= '0;
            r_tp    <= '0;
            r_tq    <= '0;
            r_cnt   <= '0;
        end
    end

    // result register, signs restored and divisor saturated
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_divisor <= r_small[W-1] ? '1 : r_small[W-2:0];
            r_coef_a  <= r_neg_a ? (W'(0) - w_ka_mag) : w_ka_mag;
            r_coef_b  <= r_neg_b ? (W'(0) - w_lb_mag) : w_lb_mag;
        end
    end

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.divisor = r_divisor;
    assign o_out.coef_a  = r_coef_a;
    assign o_out.coef_b  = r_coef_b;

endmodule

// ===== rtl/sxg_chk.sv =====
// ----------------------------------------------------------------------------
// sxg_chk
// port-level checks of the signed extended gcd unit, bound to the top level
// ----------------------------------------------------------------------------
module sxg_chk import sxg_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_WIDTH-2:0] i_divisor,
    input logic [DATA_WIDTH-1:0] i_coef_a,
    input logic [DATA_WIDTH-1:0] i_coef_b
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_divisor)
            && $stable(i_coef_a) && $stable(i_coef_b))
        else $error("result beat changed under stall");

    // one operand beat at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    // a new result leaves the unit idle
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result shown while still busy");

    // zero gcd (two zero operands) carries coef_a 0 and coef_b 1
    a_zero_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_divisor == '0 |-> i_coef_a == '0
            && i_coef_b == DATA_WIDTH'(1))
        else $error("bad coefficients for zero gcd");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind signed_extended_gcd_unit sxg_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_sxg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_divisor   (o_out.divisor),
    .i_coef_a    (o_out.coef_a),
    .i_coef_b    (o_out.coef_b)
);

// ===== verif/signed_extended_gcd_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_extended_gcd_unit_tb
// self-checking bench: directed operand pairs (zeros, equal magnitudes, mixed
// signs, largest magnitudes, long fibonacci chains) and then random pairs
// (full range, small, common factors, multiples, zeros, equal magnitudes,
// fibonacci chains) go through a bursty sender; every result beat is compared
// against a typed expectation or an in-bench bezout predictor while the
// receiver stalls on its own random pattern
module signed_extended_gcd_unit_tb;
    import sxg_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int RANDOM_PAIRS = 425;
    localparam logic [63:0] WORD_MASK = ~64'h0 >> (64 - DW);
    localparam logic [63:0] DIV_MASK = ~64'h0 >> (65 - DW);

    typedef logic signed [DW-1:0] t_word;
    typedef logic [DW-2:0] t_div;

    typedef struct packed {
        t_div  divisor;
        t_word coef_a;
        t_word coef_b;
    } t_bezout;

    typedef struct packed {
        t_word a;
        t_word b;
        logic  known;
        t_div  divisor;
        t_word coef_a;
        t_word coef_b;
    } t_gcd_case;

    localparam t_word MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam t_word MINV = {1'b1, {(DW-1){1'b0}}};
    localparam t_div DMAX = '1;

    logic i_clk;
    logic i_rst_n;

    sxg_in_if  #(.DATA_WIDTH(DW)) in_ch ();
    sxg_out_if #(.DATA_WIDTH(DW)) out_ch ();

    signed_extended_gcd_unit #(.DATA_WIDTH(DW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_bezout pending_bezout[$];
    int      mismatch_count = 0;
    int      burst_left = 0;
    int      stall_left = 0;
    int      flow_left = 0;

    t_gcd_case directed_cases [25] = '{
        '{0, 0, 1'b1, 0, 0, 1},
        '{0, 5, 1'b1, 5, 0, 1},
        '{0, -7, 1'b1, 7, 0, -1},
        '{9, 0, 1'b1, 9, 1, 0},
        '{-9, 0, 1'b1, 9, -1, 0},
        '{MAXV, 0, 1'b1, DMAX, 1, 0},
        '{0, -MAXV, 1'b1, DMAX, 0, -1},
        '{6, 6, 1'b1, 6, 0, 1},
        '{6, -6, 1'b1, 6, 1, 0},
        '{-6, 6, 1'b1, 6, 0, 1},
        '{-6, -6, 1'b1, 6, 0, -1},
        '{MAXV, MAXV, 1'b1, DMAX, 0, 1},
        '{MAXV, -MAXV, 1'b1, DMAX, 1, 0},
        '{-MAXV, -MAXV, 1'b1, DMAX, 0, -1},
        '{MAXV, 1, 1'b1, 1, 0, 1},
        '{1, MAXV, 1'b1, 1, 1, 0},
        '{-1, 1, 1'b1, 1, 0, 1},
        '{240, 46, 1'b0, 0, 0, 0},
        '{-240, 46, 1'b0, 0, 0, 0},
        '{46, -240, 1'b0, 0, 0, 0},
        '{-46, -240, 1'b0, 0, 0, 0},
        '{12, -18, 1'b0, 0, 0, 0},
        '{1836311903, 1134903170, 1'b0, 0, 0, 0},
        '{-1134903170, 1836311903, 1'b0, 0, 0, 0},
        '{MAXV, MAXV - 1, 1'b0, 0, 0, 0}
    };

    // positive euclid on nonzero x, y with coefficients mod 2^64
    function automatic void euclid_chain(input logic [63:0] x, input logic [63:0] y,
                                         output logic [63:0] cx, output logic [63:0] cy,
                                         output logic [63:0] g);
        logic [63:0] rem, big, sml, p0, q0, p1, q1, quo, t;
        rem = x % y;
        if (rem == 0) begin
            cx = 0;
            cy = 1;
            g  = y;
        end else begin
            p0  = 0;
            q0  = 1;
            p1  = 1;
            q1  = 64'h0 - x / y;
            big = y;
            sml = rem;
            rem = big % sml;
            while (rem != 0) begin
                quo = big / sml;
                t   = p1;
                p1  = p0 - quo * p1;
                p0  = t;
                t   = q1;
                q1  = q0 - quo * q1;
                q0  = t;
                big = sml;
                sml = rem;
                rem = big % sml;
            end
            cx = p1;
            cy = q1;
            g  = sml;
        end
    endfunction

    function automatic t_bezout predict_bezout(t_word a, t_word b);
        logic [63:0] ua, ub, mag_a, mag_b, g, ka, lb;
        logic        neg_a, neg_b, swap;
        t_bezout     r;
        ua = '0;
        ub = '0;
        ua[DW-1:0] = a;
        ub[DW-1:0] = b;
        neg_a = a[DW-1];
        neg_b = b[DW-1];
        mag_a = neg_a ? ((64'h0 - ua) & WORD_MASK) : ua;
        mag_b = neg_b ? ((64'h0 - ub) & WORD_MASK) : ub;
        if (mag_a == 0) begin
            g  = mag_b;
            ka = 0;
            lb = 1;
        end else if (mag_b == 0) begin
            g  = mag_a;
            ka = 1;
            lb = 0;
        end else begin
            swap = (mag_a < mag_b) || (mag_a == mag_b && !neg_a && neg_b);
            if (swap) begin
                euclid_chain(mag_b, mag_a, lb, ka, g);
            end else begin
                euclid_chain(mag_a, mag_b, ka, lb, g);
            end
        end
        if (neg_a) ka = 64'h0 - ka;
        if (neg_b) lb = 64'h0 - lb;
        if (g > DIV_MASK) g = DIV_MASK;
        r.divisor = g[DW-2:0];
        r.coef_a  = ka[DW-1:0];
        r.coef_b  = lb[DW-1:0];
        return r;
    endfunction

    function automatic t_word random_sign(t_word v);
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    function automatic t_word full_range_operand();
        t_word v;
        v = $urandom;
        while (v == MINV) v = $urandom;
        return v;
    endfunction

    task automatic random_pair(output t_word a, output t_word b);
        int unsigned k, x, y, n;
        logic [63:0] f0, f1, t;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                a = full_range_operand();
                b = full_range_operand();
            end
            4: begin
                a = random_sign($urandom_range(0, 200));
                b = random_sign($urandom_range(0, 200));
            end
            5: begin
                // shared factor
                k = $urandom_range(1, 50000);
                x = $urandom_range(1, 40000);
                y = $urandom_range(1, 40000);
                a = random_sign(k * x);
                b = random_sign(k * y);
            end
            6: begin
                a = full_range_operand();
                b = 0;
                if ($urandom_range(0, 1) == 1) begin
                    b = a;
                    a = 0;
                end
            end
            7: begin
                a = full_range_operand();
                b = random_sign(a[DW-1] ? -a : a);
            end
            8: begin
                // consecutive fibonacci numbers, longest euclid chains
                n  = $urandom_range(20, 45);
                f0 = 0;
                f1 = 1;
                repeat (n) begin
                    t  = f1;
                    f1 = f0 + f1;
                    f0 = t;
                end
                a = random_sign(f1[DW-1:0]);
                b = random_sign(f0[DW-1:0]);
                if ($urandom_range(0, 1) == 1) begin
                    a = b;
                    b = random_sign(f1[DW-1:0]);
                end
            end
            default: begin
                x = $urandom_range(1, 65535);
                k = $urandom_range(1, 32767);
                a = random_sign(k * x);
                b = random_sign(x);
            end
        endcase
    endtask

    task automatic send_pair(t_word a, t_word b, logic known, t_bezout typed);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_bezout.push_back(known ? typed : predict_bezout(a, b));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_bezout.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result checking and receiver stall pattern
    always @(posedge i_clk) begin
        t_bezout want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_bezout.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: divisor %0d coef_a %0d coef_b %0d",
                                 out_ch.divisor, out_ch.coef_a, out_ch.coef_b);
                end else begin
                    want = pending_bezout.pop_front();
                    if (out_ch.divisor !== want.divisor || out_ch.coef_a !== want.coef_a ||
                        out_ch.coef_b !== want.coef_b) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                                     want.divisor, want.coef_a, want.coef_b,
                                     out_ch.divisor, out_ch.coef_a, out_ch.coef_b);
                    end
                end
            end
            if (flow_left > 0) begin
                flow_left--;
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                flow_left    = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 2000)
                                                           : $urandom_range(0, 40);
                stall_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_word   a, b;
        t_bezout typed;
        in_ch.valid     <= 1'b0;
        in_ch.operand_a <= '0;
        in_ch.operand_b <= '0;
        i_rst_n         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_cases[i]) begin
            typed = '{directed_cases[i].divisor, directed_cases[i].coef_a,
                      directed_cases[i].coef_b};
            send_pair(directed_cases[i].a, directed_cases[i].b, directed_cases[i].known,
                      typed);
        end
        wait_drained();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == RANDOM_PAIRS / 2) wait_drained();
            random_pair(a, b);
            send_pair(a, b, 1'b0, '0);
        end
        wait_drained();
        repeat (50) @(posedge i_clk);

        if (mismatch_count == 0 && pending_bezout.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== signed_extended_gcd_unit.f =====
rtl/sxg_pkg.sv
rtl/sxg_if.sv
rtl/signed_extended_gcd_unit.sv
rtl/sxg_chk.sv
verif/signed_extended_gcd_unit_tb.sv
